>>> design/multi_tone_sine_adder_unit_macros.svh
// Assertion macros for the multi-tone sine adder checker
`ifndef MULTI_TONE_SINE_ADDER_UNIT_MACROS_SVH
`define MULTI_TONE_SINE_ADDER_UNIT_MACROS_SVH

// Same-cycle implication, switched off during reset
`define MTSA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtsa checker: implication failed");

// Next-cycle implication, switched off during reset
`define MTSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtsa checker: next-cycle implication failed");

// Next-cycle implication that also holds across reset
`define MTSA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mtsa checker: reset behaviour failed");

`endif

>>> design/mtsa_pkg.sv
// Shared types, constants and sine table helper for the multi-tone sine adder
package mtsa_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int STEP_W      = 32;
  localparam int GAIN_W      = 16;
  localparam int SINE_W      = 15;  // table magnitude, 0..32767
  localparam int PROD_W      = 32;
  localparam int PROD_SHIFT  = 15;
  localparam int TERM_W      = PROD_W - PROD_SHIFT;
  localparam int QUAD_BITS   = 2;
  localparam int MAX_TONES   = 4;
  localparam int SUM_W       = SAMPLE_W + 3;

  localparam int NUM_TONES_DEF      = 4;
  localparam int SINE_ADDR_BITS_DEF = 10;

  // Configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_GAIN_BASE = 3'd4;

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 24'sh800000;

  // Two pi in Q30 radians
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] SINE_MAX   = 64'd32767;

  // Pipeline advance controls handed to every tone lane
  typedef struct packed {
    logic load1;    // input transfer, phase advance and table read
    logic load2;    // product register load
    logic restart;  // zero phases before this sample
  } pipe_ctl_t;

  // Quarter-wave entry k: Q30 Taylor series to the x^11 term, rounded to Q15
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] k,
                                                     input int unsigned sab);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x    = (64'(k) * TWO_PI_Q30) >> sab;
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    q = (64'(sum) + 64'd16384) >> 15;
    if (q > SINE_MAX) begin
      q = SINE_MAX;
    end
    return q[SINE_W-1:0];
  endfunction

endpackage

>>> design/mtsa_stream_if.sv
// Stream channel interfaces for sample input and result output
interface mtsa_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mtsa_pkg::SAMPLE_W-1:0] base_sample;
  logic                               restart;

  modport source (output valid, output base_sample, output restart, input ready);
  modport sink   (input valid, input base_sample, input restart, output ready);
endinterface

interface mtsa_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mtsa_pkg::SAMPLE_W-1:0] out_sample;
  logic                               saturated;

  modport source (output valid, output out_sample, output saturated, input ready);
  modport sink   (input valid, input out_sample, input saturated, output ready);
endinterface

>>> design/mtsa_sine_rom.sv
// Quarter-wave sine table with a registered read port
module mtsa_sine_rom #(
  parameter int SINE_ADDR_BITS = mtsa_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [SINE_ADDR_BITS-2:0]     rd_addr,
  output logic [mtsa_pkg::SINE_W-1:0]   rd_data
);
  import mtsa_pkg::*;

  localparam int QLEN = 1 << (SINE_ADDR_BITS - QUAD_BITS);

  typedef logic [SINE_W-1:0] qw_t [QLEN+1];

  function automatic qw_t build_qw();
    qw_t tbl;
    for (int k = 0; k <= QLEN; k++) begin
      tbl[k] = quarter_sine(32'(k), SINE_ADDR_BITS);
    end
    return tbl;
  endfunction

  localparam qw_t QW = build_qw();

  // Read on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= QW[rd_addr];
    end
  end

endmodule

>>> design/mtsa_tone_lane.sv
// One tone: phase accumulator, sine lookup and scaled gain product
module mtsa_tone_lane #(
  parameter int SINE_ADDR_BITS = mtsa_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mtsa_pkg::pipe_ctl_t                ctl,
  input  logic [mtsa_pkg::STEP_W-1:0]        step,
  input  logic signed [mtsa_pkg::GAIN_W-1:0] gain,
  output logic signed [mtsa_pkg::TERM_W-1:0] term
);
  import mtsa_pkg::*;

  localparam int IDX_W = SINE_ADDR_BITS - 1;
  localparam int QLEN  = 1 << (SINE_ADDR_BITS - QUAD_BITS);

  logic [STEP_W-1:0]          phase;
  logic [STEP_W-1:0]          phase_use;
  logic [SINE_ADDR_BITS-1:0]  addr;
  logic [QUAD_BITS-1:0]       quad;
  logic [IDX_W-1:0]           offs;
  logic [IDX_W-1:0]           idx;
  logic [SINE_W-1:0]          mag;
  logic                       neg;
  logic signed [GAIN_W-1:0]   sine;
  logic signed [PROD_W-1:0]   prod;

  // Phase seen by this sample, after an optional restart
  assign phase_use = ctl.restart ? '0 : phase;

  // Fold the address onto the quarter wave
  assign addr = phase_use[STEP_W-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: QUAD_BITS];
  assign offs = {1'b0, addr[SINE_ADDR_BITS-QUAD_BITS-1:0]};
  assign idx  = quad[0] ? (IDX_W'(QLEN) - offs) : offs;

  // Advance phase on each transfer, wrapping modulo the word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctl.load1) begin
      phase <= phase_use + step;
    end
  end

  // Hold the sign of the half wave alongside the table read
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      neg <= quad[1];
    end
  end

  mtsa_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (ctl.load1),
    .rd_addr (idx),
    .rd_data (mag)
  );

  // Signed sine times gain, floored by the Q15 shift
  assign sine = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign prod = PROD_W'(gain) * PROD_W'(sine);

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      term <= prod[PROD_W-1:PROD_SHIFT];
    end
  end

endmodule

>>> design/multi_tone_sine_adder_unit.sv
// Top level of the multi-tone sine adder
//
//   channel      dir   payload                         transfer
//   sample_in    in    base_sample[24], restart        valid & ready
//   sample_out   out   out_sample[24], saturated       valid & ready
//   cfg          in    cfg_index[3], cfg_data[32]      cfg_write
//
// Three register stages: table read, gain product, sum and saturate.
// One sample enters and one result leaves per cycle while sample_out is ready.
// Reset clears phases, tone registers and all stage valids.
// A stalled output holds its result; the stages behind it keep filling,
// and sample_in.ready drops only once every stage is full.
module multi_tone_sine_adder_unit #(
  parameter int NUM_TONES      = mtsa_pkg::NUM_TONES_DEF,
  parameter int SINE_ADDR_BITS = mtsa_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  mtsa_in_if.sink                             sample_in,
  mtsa_out_if.source                          sample_out,
  input  logic                                cfg_write,
  input  logic [mtsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mtsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtsa_pkg::*;

  logic [STEP_W-1:0]          tone_step [NUM_TONES];
  logic signed [GAIN_W-1:0]   tone_gain [NUM_TONES];
  logic signed [TERM_W-1:0]   term      [NUM_TONES];

  logic                       v1, v2, v3;
  logic                       free1, free2, free3;
  logic                       load3;
  pipe_ctl_t                  ctl;
  logic signed [SAMPLE_W-1:0] base1, base2;
  logic signed [SUM_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] out_sample_next;
  logic                       saturated_next;

  // Tone registers; writes to tones beyond NUM_TONES are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        tone_step[t] <= '0;
        tone_gain[t] <= '0;
      end
    end else if (cfg_write) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        if (cfg_index == REG_TONE_STEP_BASE + CFG_INDEX_W'(t)) begin
          tone_step[t] <= cfg_data[STEP_W-1:0];
        end
        if (cfg_index == REG_TONE_GAIN_BASE + CFG_INDEX_W'(t)) begin
          tone_gain[t] <= cfg_data[GAIN_W-1:0];
        end
      end
    end
  end

  // Stage advance: each stage loads when the one after it is empty or moving
  assign free3     = !v3 || sample_out.ready;
  assign load3     = v2 && free3;
  assign free2     = !v2 || load3;
  assign ctl.load2 = v1 && free2;
  assign free1     = !v1 || ctl.load2;
  assign ctl.load1 = sample_in.valid && free1;
  assign ctl.restart = sample_in.restart;

  assign sample_in.ready  = free1;
  assign sample_out.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.load1 || (v1 && !ctl.load2);
      v2 <= ctl.load2 || (v2 && !load3);
      v3 <= load3 || (v3 && !sample_out.ready);
    end
  end

  // Carry the base sample alongside the tone lanes
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      base1 <= sample_in.base_sample;
    end
    if (ctl.load2) begin
      base2 <= base1;
    end
  end

  for (genvar g = 0; g < NUM_TONES; g++) begin : g_lane
    mtsa_tone_lane #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .step (tone_step[g]),
      .gain (tone_gain[g]),
      .term (term[g])
    );
  end

  // Sum base and tone terms, then clip to the sample range
  always_comb begin
    acc = SUM_W'(base2);
    for (int t = 0; t < NUM_TONES; t++) begin
      acc = acc + SUM_W'(term[t]);
    end
    if (acc > SUM_W'(OUT_MAX)) begin
      out_sample_next = OUT_MAX;
      saturated_next  = 1'b1;
    end else if (acc < SUM_W'(OUT_MIN)) begin
      out_sample_next = OUT_MIN;
      saturated_next  = 1'b1;
    end else begin
      out_sample_next = acc[SAMPLE_W-1:0];
      saturated_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      sample_out.out_sample <= out_sample_next;
      sample_out.saturated  <= saturated_next;
    end
  end

endmodule

>>> design/mtsa_checker.sv
// Port-level checks on the multi-tone sine adder, bound to its top level
`include "multi_tone_sine_adder_unit_macros.svh"

module mtsa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mtsa_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                saturated
);
  import mtsa_pkg::*;

  // Result register comes up empty out of reset
  `MTSA_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // A clipped result sits exactly on a range limit
  `MTSA_ASSERT_IMPL(a_sat_limit, clk, rst, out_valid && saturated, out_sample == OUT_MAX || out_sample == OUT_MIN)

  // With the output drained while it passes the stages, an accepted sample emerges
  `MTSA_ASSERT_NEXT(a_latency, clk, rst, (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready, out_valid)

  // A stalled result holds
  `MTSA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(saturated))

endmodule

bind multi_tone_sine_adder_unit mtsa_checker u_mtsa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_in.valid),
  .in_ready   (sample_in.ready),
  .out_valid  (sample_out.valid),
  .out_ready  (sample_out.ready),
  .out_sample (sample_out.out_sample),
  .saturated  (sample_out.saturated)
);
